[src/keypad_calculator_engine_defines.svh]
// Assertion macros shared by the checker of the keypad calculator engine.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef KEYPAD_CALCULATOR_ENGINE_DEFINES_SVH
`define KEYPAD_CALCULATOR_ENGINE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define KCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kce_pkg.sv]
// Package of the keypad calculator engine: widths, command, operator and
// arithmetic unit codes, and the control structs. No dependencies.
package kce_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int FRAC_BITS   = 16;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam value_t MAXV    = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t MINV    = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t ONE     = value_t'(1) <<< FRAC_BITS;
  localparam value_t TEN_Q   = value_t'(10) <<< FRAC_BITS;
  localparam value_t TEN_INT = value_t'(10);

  // Key commands.
  localparam logic [3:0] CMD_DIGIT  = 4'd0;
  localparam logic [3:0] CMD_SETOP  = 4'd1;
  localparam logic [3:0] CMD_EQUALS = 4'd2;
  localparam logic [3:0] CMD_SWAP   = 4'd3;
  localparam logic [3:0] CMD_CLR_E  = 4'd4;
  localparam logic [3:0] CMD_CLR_A  = 4'd5;
  localparam logic [3:0] CMD_RECIP  = 4'd6;
  localparam logic [3:0] CMD_SQRT   = 4'd7;
  localparam logic [3:0] CMD_X10    = 4'd8;
  localparam logic [3:0] CMD_DIV10  = 4'd9;
  localparam logic [3:0] CMD_LOAD   = 4'd10;
  localparam logic [3:0] CMD_TOGGLE = 4'd11;

  // Pending operators.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // Arithmetic unit operations.
  localparam logic [2:0] ALU_PASS = 3'd0;
  localparam logic [2:0] ALU_ADD  = 3'd1;
  localparam logic [2:0] ALU_SUB  = 3'd2;
  localparam logic [2:0] ALU_MULQ = 3'd3;
  localparam logic [2:0] ALU_MULI = 3'd4;
  localparam logic [2:0] ALU_DIVQ = 3'd5;
  localparam logic [2:0] ALU_DIVI = 3'd6;
  localparam logic [2:0] ALU_SQRT = 3'd7;

  typedef struct packed {
    logic       start;
    logic [2:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic err;
  } alu_rsp_t;

endpackage

[src/kce_alu.sv]
// Shared iterative arithmetic unit: saturating add/subtract, shift-add
// multiply, restoring divide and digit-by-digit square root. Uses kce_pkg.
module kce_alu import kce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  input  value_t   a,
  input  value_t   b,
  output alu_rsp_t rsp,
  output value_t   res
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(2 * VW);
  localparam int RW = VW + 4;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_RUN  = 2'd1;
  localparam logic [1:0] A_FIN  = 2'd2;

  logic [1:0]    st_r;
  logic          done_r;
  logic [2:0]    op_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] opnd_r;
  logic [VW-1:0] hi_r;
  logic [VW-1:0] lo_r;
  logic [RW-1:0] rem_r;
  value_t        res_r;
  logic          err_r;

  logic [VW-1:0]   ma, mb;
  logic [VW:0]     ssum;
  logic            sovf;
  value_t          sres;
  logic [VW:0]     msum;
  logic [VW-1:0]   dsh, ddiff;
  logic            dge;
  logic [RW-1:0]   srem, strial, sdiff;
  logic            sge;
  logic [VW-1:0]   fhi, flo;
  logic            fovf;
  value_t          fres;
  logic [2*VW-1:0] nq;

  assign ma = a[VW-1] ? (~a + 1'b1) : a;
  assign mb = b[VW-1] ? (~b + 1'b1) : b;
  assign nq = {{VW{1'b0}}, ma} << FRAC_BITS;

  // Saturating add or subtract on a sign-extended word.
  always_comb begin
    if (req.op == ALU_SUB) begin
      ssum = {a[VW-1], a} - {b[VW-1], b};
    end else begin
      ssum = {a[VW-1], a} + {b[VW-1], b};
    end
    sovf = ssum[VW] ^ ssum[VW-1];
    sres = sovf ? (ssum[VW] ? MINV : MAXV) : ssum[VW-1:0];
  end

  // One step of each iteration.
  assign msum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, opnd_r} : {(VW+1){1'b0}});
  assign dsh    = {rem_r[VW-2:0], hi_r[VW-1]};
  assign dge    = rem_r[VW-1] | (dsh >= opnd_r);
  assign ddiff  = dsh - opnd_r;
  assign srem   = {rem_r[RW-3:0], hi_r[VW-1:VW-2]};
  assign strial = {{(RW-VW-2){1'b0}}, opnd_r, 2'b01};
  assign sge    = srem >= strial;
  assign sdiff  = srem - strial;

  // Final scaling and saturation of a 2*VW-bit magnitude.
  always_comb begin
    if (op_r == ALU_MULQ) begin
      fhi = hi_r >> FRAC_BITS;
      flo = {hi_r[FRAC_BITS-1:0], lo_r[VW-1:FRAC_BITS]};
    end else begin
      fhi = hi_r;
      flo = lo_r;
    end
    fovf = (fhi != '0) ||
           (neg_r ? (flo[VW-1] && (flo[VW-2:0] != '0)) : flo[VW-1]);
    if (fovf) begin
      fres = neg_r ? MINV : MAXV;
    end else begin
      fres = neg_r ? (~flo + 1'b1) : flo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              ALU_MULQ, ALU_MULI: st_r <= A_RUN;
              ALU_DIVQ, ALU_DIVI: begin
                if (mb == '0) begin
                  done_r <= 1'b1;
                end else begin
                  st_r <= A_RUN;
                end
              end
              ALU_SQRT: begin
                if (a[VW-1]) begin
                  done_r <= 1'b1;
                end else begin
                  st_r <= A_RUN;
                end
              end
              default: done_r <= 1'b1;
            endcase
          end
        end
        A_RUN: begin
          if (cnt_r == '0) begin
            st_r <= A_FIN;
          end
        end
        A_FIN: begin
          done_r <= 1'b1;
          st_r   <= A_IDLE;
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      A_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          err_r <= 1'b0;
          neg_r <= a[VW-1] ^ b[VW-1];
          rem_r <= '0;
          case (req.op)
            ALU_ADD, ALU_SUB: begin
              res_r <= sres;
              err_r <= sovf;
            end
            ALU_MULQ, ALU_MULI: begin
              opnd_r <= ma;
              hi_r   <= '0;
              lo_r   <= mb;
              cnt_r  <= CW'(VW - 1);
            end
            ALU_DIVQ, ALU_DIVI: begin
              res_r  <= '0;
              err_r  <= (mb == '0);
              opnd_r <= mb;
              if (req.op == ALU_DIVQ) begin
                {hi_r, lo_r} <= nq;
              end else begin
                {hi_r, lo_r} <= {{VW{1'b0}}, ma};
              end
              cnt_r <= CW'(2 * VW - 1);
            end
            ALU_SQRT: begin
              res_r        <= '0;
              err_r        <= a[VW-1];
              opnd_r       <= '0;
              {hi_r, lo_r} <= nq;
              cnt_r        <= CW'(VW - 1);
            end
            default: res_r <= a;
          endcase
        end
      end
      A_RUN: begin
        cnt_r <= cnt_r - 1'b1;
        case (op_r)
          ALU_MULQ, ALU_MULI: begin
            hi_r <= msum[VW:1];
            lo_r <= {msum[0], lo_r[VW-1:1]};
          end
          ALU_DIVQ, ALU_DIVI: begin
            rem_r        <= {{(RW-VW){1'b0}}, (dge ? ddiff : dsh)};
            {hi_r, lo_r} <= {hi_r[VW-2:0], lo_r, dge};
          end
          default: begin
            rem_r        <= sge ? sdiff : srem;
            opnd_r       <= {opnd_r[VW-2:0], sge};
            {hi_r, lo_r} <= {hi_r[VW-3:0], lo_r, 2'b00};
          end
        endcase
      end
      A_FIN: begin
        if (op_r == ALU_SQRT) begin
          res_r <= opnd_r;
        end else begin
          res_r <= fres;
          err_r <= fovf;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.err  = err_r;
  assign res      = res_r;

endmodule

[src/keypad_calculator_engine.sv]
// Channel  | direction | handshake           | payload
// in_      | input     | in_valid / in_stall | command, digit, operator_code, typed_integer
// out_     | output    | out_valid/out_stall | entry, held, operator, shown, view, error
//
// One command is taken at a time; in_stall stays high until its result is taken.
// Reciprocal with a pending divide runs two divides and takes the longest. The
// arithmetic runs on the shared arithmetic unit: one bit per cycle for multiply
// (64 steps) and divide (128 steps), two radicand bits per cycle for the root
// (64 steps).
// Reset clears the control state and the calculator registers; a stalled result holds until out_stall falls.
module keypad_calculator_engine import kce_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_command,
  input  logic [3:0]                    in_digit,
  input  logic [2:0]                    in_operator_code,
  input  logic signed [31:0]            in_typed_integer,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_entry_value,
  output logic signed [VALUE_WIDTH-1:0] out_held_value,
  output logic [2:0]                    out_pending_operator,
  output logic                          out_result_shown,
  output logic                          out_binary_view,
  output logic                          out_error_flag
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_RUN1 = 3'd2;
  localparam logic [2:0] ST_MID  = 3'd3;
  localparam logic [2:0] ST_RUN2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         st_r, st_nxt;
  logic [3:0]         cmd_r, dig_r;
  logic [2:0]         opc_r;
  logic signed [31:0] typed_r;
  value_t             entry_r, entry_nxt;
  value_t             held_r, held_nxt;
  logic [2:0]         pend_r, pend_nxt;
  logic               shown_r, shown_nxt;
  logic               bin_r, bin_nxt;
  logic               err_r, err_nxt;
  value_t             res_r, res_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  value_t   alu_a, alu_b, alu_res;
  logic     accept, needs_eval;
  logic [2:0] pend_alu;
  value_t   dig_q, typed_q;

  assign accept = in_valid && (st_r == ST_IDLE);
  assign dig_q  = value_t'(dig_r) <<< FRAC_BITS;
  assign typed_q = value_t'(typed_r) <<< FRAC_BITS;

  assign needs_eval = (cmd_r == CMD_EQUALS) ||
                      (((cmd_r == CMD_SETOP) || (cmd_r == CMD_RECIP) ||
                        (cmd_r == CMD_SQRT) || (cmd_r == CMD_X10)) && (entry_r != '0));

  always_comb begin
    case (pend_r)
      OP_ADD:  pend_alu = ALU_ADD;
      OP_SUB:  pend_alu = ALU_SUB;
      OP_MUL:  pend_alu = ALU_MULQ;
      OP_DIV:  pend_alu = ALU_DIVQ;
      default: pend_alu = ALU_PASS;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    entry_nxt     = entry_r;
    held_nxt      = held_r;
    pend_nxt      = pend_r;
    shown_nxt     = shown_r;
    bin_nxt       = bin_r;
    err_nxt       = err_r;
    res_nxt       = res_r;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_PASS;
    alu_a         = entry_r;
    alu_b         = entry_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          err_nxt = 1'b0;
          st_nxt  = ST_DEC;
        end
      end
      ST_DEC: begin
        st_nxt = ST_OUT;
        case (cmd_r)
          CMD_DIGIT, CMD_DIV10: begin
            alu_req.start = 1'b1;
            alu_req.op    = (cmd_r == CMD_DIGIT) ? ALU_MULI : ALU_DIVI;
            alu_b         = TEN_INT;
            st_nxt        = ST_RUN1;
          end
          CMD_SETOP, CMD_EQUALS, CMD_RECIP, CMD_SQRT, CMD_X10: begin
            if (needs_eval && (pend_r != OP_NONE)) begin
              alu_req.start = 1'b1;
              alu_req.op    = pend_alu;
              alu_a         = (cmd_r == CMD_X10) ? entry_r : held_r;
              st_nxt        = ST_RUN1;
            end else begin
              // Without an operation the left operand is the entry or the held value.
              res_nxt = (needs_eval || (cmd_r == CMD_X10)) ? entry_r : held_r;
              st_nxt  = ST_MID;
            end
          end
          CMD_SWAP: begin
            entry_nxt = held_r;
            held_nxt  = entry_r;
          end
          CMD_CLR_E: entry_nxt = '0;
          CMD_CLR_A: begin
            entry_nxt = '0;
            held_nxt  = '0;
            pend_nxt  = OP_NONE;
            shown_nxt = 1'b0;
          end
          CMD_LOAD: begin
            if (!bin_r) begin
              entry_nxt = typed_q;
            end
          end
          CMD_TOGGLE: bin_nxt = ~bin_r;
          default: ;
        endcase
      end
      ST_RUN1: begin
        if (alu_rsp.done) begin
          res_nxt = alu_res;
          err_nxt = err_r | alu_rsp.err;
          st_nxt  = ST_MID;
        end
      end
      ST_MID: begin
        st_nxt = ST_OUT;
        alu_a  = res_r;
        case (cmd_r)
          CMD_DIGIT: begin
            // A saturated product is the result; the digit is not added.
            if (err_r) begin
              entry_nxt = res_r;
              shown_nxt = 1'b0;
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = ALU_ADD;
              alu_b         = dig_q;
              st_nxt        = ST_RUN2;
            end
          end
          CMD_EQUALS: begin
            entry_nxt = res_r;
            held_nxt  = '0;
            pend_nxt  = OP_NONE;
            shown_nxt = 1'b1;
          end
          CMD_SETOP: begin
            held_nxt  = res_r;
            pend_nxt  = opc_r;
            entry_nxt = '0;
            shown_nxt = 1'b0;
          end
          CMD_RECIP: begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_DIVQ;
            alu_a         = ONE;
            alu_b         = res_r;
            st_nxt        = ST_RUN2;
          end
          CMD_SQRT: begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_SQRT;
            st_nxt        = ST_RUN2;
          end
          CMD_X10: begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_MULQ;
            alu_b         = TEN_Q;
            st_nxt        = ST_RUN2;
          end
          CMD_DIV10: entry_nxt = res_r;
          default: ;
        endcase
      end
      ST_RUN2: begin
        if (alu_rsp.done) begin
          entry_nxt = alu_res;
          err_nxt   = err_r | alu_rsp.err;
          if (cmd_r == CMD_DIGIT) begin
            shown_nxt = 1'b0;
          end else begin
            held_nxt  = '0;
            pend_nxt  = OP_NONE;
            shown_nxt = 1'b1;
          end
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      entry_r <= '0;
      held_r  <= '0;
      pend_r  <= OP_NONE;
      shown_r <= 1'b0;
      bin_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      entry_r <= entry_nxt;
      held_r  <= held_nxt;
      pend_r  <= pend_nxt;
      shown_r <= shown_nxt;
      bin_r   <= bin_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      cmd_r   <= in_command;
      dig_r   <= (in_digit >= 4'd10) ? (in_digit - 4'd10) : in_digit;
      opc_r   <= (in_operator_code <= OP_DIV) ? in_operator_code : OP_NONE;
      typed_r <= in_typed_integer;
    end
  end

  kce_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .b     (alu_b),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  assign in_stall             = (st_r != ST_IDLE);
  assign out_valid            = (st_r == ST_OUT);
  assign out_entry_value      = entry_r;
  assign out_held_value       = held_r;
  assign out_pending_operator = pend_r;
  assign out_result_shown     = shown_r;
  assign out_binary_view      = bin_r;
  assign out_error_flag       = err_r;

endmodule

[src/kce_checker.sv]
// Port-level checker for the keypad calculator engine and its bind.
// Depends on kce_pkg and keypad_calculator_engine_defines.svh.
`include "keypad_calculator_engine_defines.svh"

module kce_checker import kce_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [3:0]                    in_command,
  input logic [3:0]                    in_digit,
  input logic [2:0]                    in_operator_code,
  input logic signed [31:0]            in_typed_integer,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [VALUE_WIDTH-1:0] out_entry_value,
  input logic signed [VALUE_WIDTH-1:0] out_held_value,
  input logic [2:0]                    out_pending_operator,
  input logic                          out_result_shown,
  input logic                          out_binary_view,
  input logic                          out_error_flag
);

  // A result waiting at the output must keep its value.
  `KCE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_entry_value), "stalled result changed")

  // Only one transaction is in flight at a time.
  `KCE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  `KCE_ASSERT_NOW(a_no_accept_with_result, out_valid, in_stall, "input open while result pending")

  // An evaluated result always leaves no operator pending.
  `KCE_ASSERT_NOW(a_shown_no_op, out_valid && out_result_shown, out_pending_operator == OP_NONE, "operator pending with result shown")

endmodule

bind keypad_calculator_engine kce_checker u_kce_checker (.*);
